### rtl/core/jqps_pkg.sv
`default_nettype none

package jqps_pkg;

   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DRAIN   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEQ,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Control from the sequencer to the shared compare unit.
   typedef struct packed {
      logic clear;
      logic cand_valid;
   } best_ctrl_type;

endpackage

`default_nettype wire

### rtl/core/jqps_if.sv
`default_nettype none

// Request channel: one item is a command with an optional job.
interface jqps_req_if #(
   parameter int VALUE_BITS = 16
);
   logic                               valid;
   logic                               ready;
   logic [jqps_pkg::MODE_W-1:0]        mode;
   logic signed [VALUE_BITS-1:0]       priority_req;
   logic signed [VALUE_BITS-1:0]       duration;

   modport source (output valid, mode, priority_req, duration, input ready);
   modport sink   (input valid, mode, priority_req, duration, output ready);
endinterface

// Response channel: one item is a status with an optional job.
interface jqps_rsp_if #(
   parameter int VALUE_BITS = 16
);
   logic                               valid;
   logic                               ready;
   logic [jqps_pkg::STATUS_W-1:0]      status;
   logic                               job_valid;
   logic signed [VALUE_BITS-1:0]       out_priority;
   logic signed [VALUE_BITS-1:0]       out_duration;
   logic                               last;

   modport source (output valid, status, job_valid, out_priority, out_duration, last,
                   input ready);
   modport sink   (input valid, status, job_valid, out_priority, out_duration, last,
                   output ready);
endinterface

`default_nettype wire

### rtl/core/jqps_best_unit.sv
`default_nettype none

module jqps_best_unit #(
   parameter int VALUE_BITS = 16,
   parameter int SLOT_W     = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire jqps_pkg::best_ctrl_type       ctrl,
   input  wire logic signed [VALUE_BITS-1:0]  cand_pri,
   input  wire logic signed [VALUE_BITS-1:0]  cand_dur,
   input  wire logic [SLOT_W-1:0]             cand_slot,
   output logic                               best_found,
   output logic signed [VALUE_BITS-1:0]       best_pri,
   output logic signed [VALUE_BITS-1:0]       best_dur,
   output logic [SLOT_W-1:0]                  best_slot
);
   import jqps_pkg::*;

   logic                          found_ff, found_in;
   logic signed [VALUE_BITS-1:0]  pri_ff, dur_ff;
   logic [SLOT_W-1:0]             slot_ff;
   logic                          take;

   // Candidates arrive oldest first, so a tie replaces the holder and the
   // newest of equal priority wins.
   assign take     = ctrl.cand_valid && (!found_ff || (cand_pri >= pri_ff));
   assign found_in = ctrl.clear ? 1'b0 : (found_ff || take);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !ctrl.clear) begin
         pri_ff  <= cand_pri;
         dur_ff  <= cand_dur;
         slot_ff <= cand_slot;
      end
   end

   assign best_found = found_ff;
   assign best_pri   = pri_ff;
   assign best_dur   = dur_ff;
   assign best_slot  = slot_ff;

endmodule

`default_nettype wire

### rtl/core/job_queue_priority_sort.sv
// Enqueue results are registered directly; a dequeue first reads the store into the
// read data register. A finish item with n stored jobs runs n selection passes:
// n store reads into the shared compare unit, a settle step, then the best job emitted.
// A finish item on an empty store, and every status-only result, is registered directly.
// Synchronous active-high reset empties the store and the result register;
// store contents are not cleared and are never read before being written.
`default_nettype none

module job_queue_priority_sort #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   jqps_req_if.sink     req_chan,
   jqps_rsp_if.source   rsp_chan
);
   import jqps_pkg::*;

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;

   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0]  ONE_COUNT  = CNT_W'(1);

   // The job store is a single-port style memory: one write or one read a
   // cycle, read data registered.
   logic [2*VALUE_BITS-1:0] store_mem [DEPTH];
   logic [2*VALUE_BITS-1:0] rd_data_ff;
   logic                    rd_en, wr_en;
   logic [SLOT_W-1:0]       rd_addr, wr_addr;

   // Sequencer and queue bookkeeping.
   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  oldest_ff, oldest_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // Selection pass bookkeeping. The taken bits mark jobs already emitted
   // during the current finish item, one bit per physical slot.
   logic [SLOT_W-1:0]  scan_slot_ff, scan_slot_in;
   logic [CNT_W-1:0]   scan_left_ff, scan_left_in;
   logic [CNT_W-1:0]   emit_left_ff, emit_left_in;
   logic [DEPTH-1:0]   taken_ff, taken_in;
   logic               cand_valid_ff, cand_valid_in;
   logic [SLOT_W-1:0]  cand_slot_ff, cand_slot_in;

   // Result register, which also decouples the two channels.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]           rsp_status_ff, rsp_status_in;
   logic                          rsp_job_ff, rsp_job_in;
   logic signed [VALUE_BITS-1:0]  rsp_pri_ff, rsp_pri_in;
   logic signed [VALUE_BITS-1:0]  rsp_dur_ff, rsp_dur_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          out_free;
   logic                          req_accept;
   logic [SUM_W-1:0]              tail_sum;
   logic [SLOT_W-1:0]             tail_slot;
   logic [SLOT_W-1:0]             oldest_next;
   logic [SLOT_W-1:0]             scan_next;

   best_ctrl_type                 best_ctrl;
   logic                          best_found;
   logic signed [VALUE_BITS-1:0]  best_pri, best_dur;
   logic [SLOT_W-1:0]             best_slot;
   logic signed [VALUE_BITS-1:0]  rd_pri, rd_dur;

   assign rd_pri = rd_data_ff[2*VALUE_BITS-1:VALUE_BITS];
   assign rd_dur = rd_data_ff[VALUE_BITS-1:0];

   // The result register can take a new item when it is empty or being
   // drained in this same cycle.
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_chan.valid && req_chan.ready;

   // Slot behind the newest job; the sum stays below twice the depth, so one
   // compare and subtract wraps it.
   assign tail_sum  = SUM_W'(oldest_ff) + SUM_W'(count_ff);
   assign tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? SLOT_W'(tail_sum - SUM_W'(DEPTH))
                                                  : SLOT_W'(tail_sum);
   assign oldest_next = (oldest_ff == LAST_SLOT) ? '0 : oldest_ff + 1'b1;
   assign scan_next   = (scan_slot_ff == LAST_SLOT) ? '0 : scan_slot_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      scan_slot_in  = scan_slot_ff;
      scan_left_in  = scan_left_ff;
      emit_left_in  = emit_left_ff;
      taken_in      = taken_ff;
      cand_valid_in = 1'b0;
      cand_slot_in  = cand_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_job_in    = rsp_job_ff;
      rsp_pri_in    = rsp_pri_ff;
      rsp_dur_in    = rsp_dur_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      rd_addr       = oldest_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_slot;
      best_ctrl.clear = 1'b0;
      // A candidate that was already emitted in an earlier pass is skipped.
      best_ctrl.cand_valid = cand_valid_ff && !taken_ff[cand_slot_ff];

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_chan.mode)
                  MODE_ENQUEUE: begin
                     // A full store drops the job and reports it.
                     rsp_valid_in = 1'b1;
                     rsp_job_in   = 1'b0;
                     rsp_pri_in   = '0;
                     rsp_dur_in   = '0;
                     rsp_last_in  = 1'b1;
                     if (count_ff == FULL_COUNT) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        rsp_status_in = STATUS_OK;
                        wr_en         = 1'b1;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  MODE_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_job_in    = 1'b0;
                        rsp_pri_in    = '0;
                        rsp_dur_in    = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = oldest_ff;
                        oldest_in = oldest_next;
                        count_in  = count_ff - 1'b1;
                        state_in  = ST_DEQ;
                     end
                  end
                  MODE_DRAIN: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_job_in    = 1'b0;
                        rsp_pri_in    = '0;
                        rsp_dur_in    = '0;
                        rsp_last_in   = 1'b1;
                        oldest_in     = '0;
                     end else begin
                        taken_in        = '0;
                        scan_slot_in    = oldest_ff;
                        scan_left_in    = count_ff;
                        emit_left_in    = count_ff;
                        best_ctrl.clear = 1'b1;
                        state_in        = ST_SCAN;
                     end
                  end
                  default: begin
                     // The unused command is ignored.
                  end
               endcase
            end
         end

         ST_DEQ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_job_in    = 1'b1;
               rsp_pri_in    = rd_pri;
               rsp_dur_in    = rd_dur;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // Read the stored jobs oldest first, one per cycle; the compare
            // unit takes each one from the registered read data.
            if (scan_left_ff != '0) begin
               rd_en         = 1'b1;
               rd_addr       = scan_slot_ff;
               scan_slot_in  = scan_next;
               scan_left_in  = scan_left_ff - 1'b1;
               cand_valid_in = 1'b1;
               cand_slot_in  = scan_slot_ff;
            end else if (!cand_valid_ff) begin
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_status_in       = STATUS_OK;
               rsp_job_in          = 1'b1;
               rsp_pri_in          = best_pri;
               rsp_dur_in          = best_dur;
               rsp_last_in         = (emit_left_ff == ONE_COUNT);
               taken_in[best_slot] = 1'b1;
               emit_left_in        = emit_left_ff - 1'b1;
               if (emit_left_ff == ONE_COUNT) begin
                  // The drained store starts over at slot zero.
                  oldest_in = '0;
                  count_in  = '0;
                  state_in  = ST_IDLE;
               end else begin
                  scan_slot_in    = oldest_ff;
                  scan_left_in    = count_ff;
                  best_ctrl.clear = 1'b1;
                  state_in        = ST_SCAN;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         oldest_ff     <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         cand_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         cand_valid_ff <= cand_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_slot_ff  <= scan_slot_in;
      scan_left_ff  <= scan_left_in;
      emit_left_ff  <= emit_left_in;
      taken_ff      <= taken_in;
      cand_slot_ff  <= cand_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_job_ff    <= rsp_job_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_dur_ff    <= rsp_dur_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= {req_chan.priority_req, req_chan.duration};
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   jqps_best_unit #(
      .VALUE_BITS (VALUE_BITS),
      .SLOT_W     (SLOT_W)
   ) u_best (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (best_ctrl),
      .cand_pri   (rd_pri),
      .cand_dur   (rd_dur),
      .cand_slot  (cand_slot_ff),
      .best_found (best_found),
      .best_pri   (best_pri),
      .best_dur   (best_dur),
      .best_slot  (best_slot)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.job_valid    = rsp_job_ff;
   assign rsp_chan.out_priority = rsp_pri_ff;
   assign rsp_chan.out_duration = rsp_dur_ff;
   assign rsp_chan.last         = rsp_last_ff;

   // Every selection pass must have found a job that was not yet emitted.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> best_found)
      else $error("emit state entered without a selected job");

   // The store never holds more jobs than it has slots, and the oldest slot stays in range.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= FULL_COUNT) && (oldest_ff <= LAST_SLOT))
      else $error("job count or oldest slot out of range");

   // The final emitted job of a finish leaves the store empty at slot zero.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && emit_left_ff == ONE_COUNT)
      |=> (count_ff == '0 && oldest_ff == '0 && state_ff == ST_IDLE))
      else $error("store not emptied after the final emitted job");

   // A stored enqueue grows the count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_chan.mode == MODE_ENQUEUE && count_ff != FULL_COUNT)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("enqueue did not advance the job count");

endmodule

`default_nettype wire
